>>> rtl/afr_pkg.sv
package afr_pkg;

  localparam logic [7:0] HDR0       = 8'hAA;
  localparam logic [7:0] HDR1       = 8'hBB;
  localparam logic [7:0] ADDR_ALL   = 8'hFF;
  localparam logic [7:0] ADDR_GROUP = 8'hEE;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER = 3'd1;
  localparam logic [2:0] ST_NOT_HERE   = 3'd2;
  localparam logic [2:0] ST_TOO_LONG   = 3'd3;
  localparam logic [2:0] ST_BAD_SUM    = 3'd4;

  localparam logic REG_OWN_ADDRESS = 1'b0;

  localparam int QUEUE_DEPTH = 4;
  localparam int POS_W       = 6;

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_DROP  = 2'd1,
    CMD_EMIT  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
  } cmd_t;

endpackage

>>> rtl/afr_front.sv
module afr_front import afr_pkg::*; #(
  parameter int FRAME_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] own_address,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_rx_byte,
  output logic       q_push,
  output cmd_t       q_wdata,
  input  logic       q_full
);

  localparam int CW = $clog2(FRAME_BYTES);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    xor_r, xor_nxt;
  logic [7:0]    len_r, len_nxt;
  logic          take;
  logic [7:0]    sum;
  logic [8:0]    cnt_w;
  logic [8:0]    len_w;

  assign in_full = q_full;
  assign take    = in_push && !q_full;
  assign sum     = xor_r ^ in_rx_byte;
  assign cnt_w   = 9'(cnt_r);
  assign len_w   = {1'b0, len_r};

  always_comb begin
    cnt_nxt      = cnt_r;
    xor_nxt      = xor_r;
    len_nxt      = len_r;
    q_push       = 1'b0;
    q_wdata.kind = CMD_STORE;
    q_wdata.pos  = POS_W'(cnt_r) - POS_W'(2);
    q_wdata.data = in_rx_byte;
    if (take) begin
      if (cnt_r == CW'(0)) begin
        if (in_rx_byte == HDR0) begin
          cnt_nxt = CW'(1);
          xor_nxt = '0;
        end
      end else if (cnt_r == CW'(1)) begin
        if (in_rx_byte != HDR1) begin
          q_push       = 1'b1;
          q_wdata.kind = CMD_DROP;
          q_wdata.data = {5'd0, ST_BAD_HEADER};
          cnt_nxt      = '0;
          xor_nxt      = '0;
        end else begin
          cnt_nxt = CW'(2);
        end
      end else if (cnt_r == CW'(2)) begin
        q_push  = 1'b1;
        xor_nxt = sum;
        cnt_nxt = CW'(3);
      end else if (cnt_r == CW'(3)) begin
        q_push = 1'b1;
        if (in_rx_byte != own_address && in_rx_byte != ADDR_ALL &&
            in_rx_byte != ADDR_GROUP) begin
          q_wdata.kind = CMD_DROP;
          q_wdata.data = {5'd0, ST_NOT_HERE};
          cnt_nxt      = '0;
          xor_nxt      = '0;
        end else begin
          xor_nxt = sum;
          cnt_nxt = CW'(4);
        end
      end else if (cnt_r == CW'(4)) begin
        q_push = 1'b1;
        if ({1'b0, in_rx_byte} + 9'd6 > 9'(FRAME_BYTES)) begin
          q_wdata.kind = CMD_DROP;
          q_wdata.data = {5'd0, ST_TOO_LONG};
          cnt_nxt      = '0;
          xor_nxt      = '0;
        end else begin
          xor_nxt = sum;
          len_nxt = in_rx_byte;
          cnt_nxt = CW'(5);
        end
      end else if (cnt_w <= len_w + 9'd4) begin
        q_push  = 1'b1;
        xor_nxt = sum;
        cnt_nxt = cnt_r + CW'(1);
      end else if (cnt_w == len_w + 9'd5) begin
        q_push  = 1'b1;
        cnt_nxt = '0;
        xor_nxt = '0;
        if (xor_r != in_rx_byte) begin
          q_wdata.kind = CMD_DROP;
          q_wdata.data = {5'd0, ST_BAD_SUM};
        end else begin
          q_wdata.kind = CMD_EMIT;
          q_wdata.data = len_r + 8'd3;
        end
      end else begin
        cnt_nxt = '0;
        xor_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      xor_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      xor_r <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

endmodule

>>> rtl/afr_queue.sv
module afr_queue import afr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output cmd_t rdata,
  output logic empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = count_r == (PW+1)'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign rdata   = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/afr_back.sv
module afr_back import afr_pkg::*; #(
  parameter int FRAME_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       q_rdata,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [2:0] out_status,
  output logic [7:0] out_frame_byte,
  output logic [4:0] out_byte_index,
  output logic       out_last
);

  localparam int AW = $clog2(FRAME_BYTES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SEND = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] k_r, k_nxt;
  logic [POS_W-1:0] n_r, n_nxt;
  logic [7:0]       rdata_r;
  logic [7:0]       mem [FRAME_BYTES];
  logic             mem_we;
  logic             valid_r, valid_nxt;
  logic             slot_free;
  logic             load;
  logic [2:0]       ld_status;
  logic [7:0]       ld_byte;
  logic [4:0]       ld_idx;
  logic             ld_last;
  logic             run_end;

  assign slot_free = !valid_r || out_pop;
  assign out_empty = !valid_r;
  assign run_end   = (k_r + POS_W'(1)) == n_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    load      = 1'b0;
    ld_status = ST_OK;
    ld_byte   = '0;
    ld_idx    = '0;
    ld_last   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          case (q_rdata.kind)
            CMD_STORE: begin
              q_pop  = 1'b1;
              mem_we = 1'b1;
            end
            CMD_DROP: begin
              if (slot_free) begin
                q_pop     = 1'b1;
                load      = 1'b1;
                ld_status = q_rdata.data[2:0];
                ld_last   = 1'b1;
              end
            end
            CMD_EMIT: begin
              q_pop     = 1'b1;
              k_nxt     = '0;
              n_nxt     = POS_W'(q_rdata.data);
              state_nxt = S_READ;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      S_READ: state_nxt = S_SEND;
      S_SEND: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_byte   = rdata_r;
          ld_idx    = 5'(k_r);
          ld_last   = run_end;
          k_nxt     = k_r + POS_W'(1);
          state_nxt = run_end ? S_IDLE : S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    n_r <= n_nxt;
    if (load) begin
      out_status     <= ld_status;
      out_frame_byte <= ld_byte;
      out_byte_index <= ld_idx;
      out_last       <= ld_last;
    end
  end

  // frame store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_rdata.pos[AW-1:0]] <= q_rdata.data;
    end
    if (state_r == S_READ) begin
      rdata_r <= mem[k_r[AW-1:0]];
    end
  end

endmodule

>>> rtl/addressed_frame_receiver.sv
// paths: a drop status goes from the parser through the command queue into the output
//   register; a good frame's results pass the queue, frame store read and output register
// throughput: one byte a cycle while the 4-entry command queue has room; a good frame's
//   run reads each result from the frame store, then loads it into the output register
// reset: synchronous active-low rst_n clears parser, queue and output valid; own_address to 1
module addressed_frame_receiver import afr_pkg::*; #(
  parameter int FRAME_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_status,
  output logic [7:0]  out_frame_byte,
  output logic [4:0]  out_byte_index,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0] own_address_r, own_address_nxt;
  logic       cfg_wr;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  cmd_t       q_wdata;
  cmd_t       q_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_OWN_ADDRESS) ? {24'd0, own_address_r} : '0;

  always_comb begin
    own_address_nxt = own_address_r;
    if (cfg_wr && cfg_paddr[2] == REG_OWN_ADDRESS && cfg_paddr[1:0] == 2'd0) begin
      own_address_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= 8'd1;
    end else begin
      own_address_r <= own_address_nxt;
    end
  end

  afr_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .own_address (own_address_r),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_rx_byte  (in_rx_byte),
    .q_push      (q_push),
    .q_wdata     (q_wdata),
    .q_full      (q_full)
  );

  afr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  afr_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_rdata        (q_rdata),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_status     (out_status),
    .out_frame_byte (out_frame_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last)
  );

endmodule

>>> rtl/afr_checker.sv
module afr_checker import afr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [2:0] out_status,
  input logic [7:0] out_frame_byte,
  input logic [4:0] out_byte_index,
  input logic       out_last,
  input logic       cfg_pready
);

  // nothing waits on the result side just after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result pending after reset");

  // a waiting result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty)
    else $error("result vanished without transaction");

  // a drop status is a run of one with cleared byte fields
  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_status != ST_OK |->
      out_last && out_frame_byte == 8'd0 && out_byte_index == 5'd0)
    else $error("malformed status result");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_status <= ST_BAD_SUM)
    else $error("status code out of range");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("config port stalled");

endmodule

bind addressed_frame_receiver afr_checker u_afr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_status     (out_status),
  .out_frame_byte (out_frame_byte),
  .out_byte_index (out_byte_index),
  .out_last       (out_last),
  .cfg_pready     (cfg_pready)
);

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import afr_pkg::*;

  localparam int FRAME_BYTES = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BYTES = 18;
  localparam logic [2:0] OWN_ADDR_OFFSET = 3'(4 * REG_OWN_ADDRESS);

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] frame_byte;
    logic [4:0] byte_index;
    logic       last;
  } rx_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_frame_byte;
  logic [4:0]  out_byte_index;
  logic        out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'h0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // frame parser copy
  logic [5:0] parse_pos = '0;
  logic [7:0] frame_mem [FRAME_BYTES];
  logic [7:0] xor_acc = '0;
  logic [7:0] node_addr = 8'h01;
  rx_result_t pending_results[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;
  int error_count = 0;
  int cycle_count = 0;
  int parsed_bytes = 0;
  int good_frames = 0;
  int results_checked = 0;
  int full_stalls = 0;
  int drop_count [5] = '{default: 0};

  addressed_frame_receiver #(.FRAME_BYTES(FRAME_BYTES)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_rx_byte    (in_rx_byte),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_status    (out_status),
    .out_frame_byte(out_frame_byte),
    .out_byte_index(out_byte_index),
    .out_last      (out_last),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 30) $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic void drop_frame(input logic [2:0] st);
    parse_pos = '0;
    xor_acc = '0;
    drop_count[st]++;
    pending_results.push_back('{st, 8'h00, 5'd0, 1'b1});
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    int len;
    if (parse_pos != 0 || b == HDR0) parsed_bytes++;
    if (parse_pos == 0) begin
      if (b == HDR0) begin
        frame_mem[0] = b;
        xor_acc = '0;
        parse_pos = 6'd1;
      end
    end else if (parse_pos == 1) begin
      if (b != HDR1) drop_frame(ST_BAD_HEADER);
      else begin
        frame_mem[1] = b;
        parse_pos = 6'd2;
      end
    end else if (parse_pos == 2) begin
      frame_mem[2] = b;
      xor_acc ^= b;
      parse_pos = 6'd3;
    end else if (parse_pos == 3) begin
      frame_mem[3] = b;
      xor_acc ^= b;
      if (b != node_addr && b != ADDR_ALL && b != ADDR_GROUP) drop_frame(ST_NOT_HERE);
      else parse_pos = 6'd4;
    end else if (parse_pos == 4) begin
      frame_mem[4] = b;
      xor_acc ^= b;
      if (int'(b) + 6 > FRAME_BYTES) drop_frame(ST_TOO_LONG);
      else parse_pos = 6'd5;
    end else begin
      len = int'(frame_mem[4]);
      if (parse_pos <= len + 4) begin
        frame_mem[parse_pos] = b;
        xor_acc ^= b;
        parse_pos = parse_pos + 6'd1;
      end else if (parse_pos == len + 5) begin
        if (xor_acc != b) drop_frame(ST_BAD_SUM);
        else begin
          for (int k = 0; k < len + 3; k++)
            pending_results.push_back('{ST_OK, frame_mem[k + 2], 5'(k), (k == len + 2)});
          good_frames++;
          parse_pos = '0;
          xor_acc = '0;
        end
      end else begin
        parse_pos = '0;
        xor_acc = '0;
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_full) begin
      full_stalls++;
      @(posedge clk);
    end
    parse_byte(b);
  endtask

  task automatic send_frame(input int length, input logic [7:0] dest, input bit bad_hdr,
                            input bit bad_sum);
    logic [7:0] frame_bytes[$];
    logic [7:0] src;
    logic [7:0] csum;
    logic [7:0] b;
    src = 8'($urandom_range(255));
    csum = src ^ dest ^ 8'(length);
    frame_bytes = {HDR0, bad_hdr ? 8'($urandom_range(255)) : HDR1, src, dest, 8'(length)};
    if (length + 6 <= FRAME_BYTES) begin
      for (int i = 0; i < length; i++) begin
        b = 8'($urandom_range(255));
        frame_bytes.push_back(b);
        csum ^= b;
      end
      if (bad_sum) csum ^= 8'($urandom_range(1, 255));
      frame_bytes.push_back(csum);
    end
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i]);
      if (parse_pos == 0) break;
    end
  endtask

  task automatic send_random_frame();
    int pick;
    int length;
    logic [7:0] dest;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      return;
    end
    pick = $urandom_range(99);
    if (pick < 55) dest = node_addr;
    else if (pick < 70) dest = ADDR_ALL;
    else if (pick < 85) dest = ADDR_GROUP;
    else dest = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 70) length = $urandom_range(0, 6);
    else if (pick < 80) length = FRAME_BYTES - 6;
    else if (pick < 92) length = $urandom_range(7, FRAME_BYTES - 7);
    else length = $urandom_range(FRAME_BYTES - 5, 255);
    send_frame(length, dest, $urandom_range(99) < 5, $urandom_range(99) < 8);
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_own_address(input logic [7:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= OWN_ADDR_OFFSET;
    cfg_pwdata <= {24'h0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    node_addr = value;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== {24'h0, value})
      report_mismatch($sformatf("own address reads %08h, wrote %02h", cfg_prdata, value));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_noise_and_header();
    send_byte(8'h00);
    send_byte(8'hFF);
    // second header byte is another start byte
    send_byte(HDR0);
    send_byte(HDR0);
    wait_idle();
  endtask

  task automatic test_drop_cases();
    send_frame(0, 8'h55, 1'b0, 1'b0);
    send_frame(FRAME_BYTES - 5, ADDR_ALL, 1'b0, 1'b0);
    send_frame(2, ADDR_ALL, 1'b0, 1'b1);
    send_frame(0, ADDR_GROUP, 1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int send_idle, input int recv_stall,
                                     input logic [7:0] address);
    int start;
    set_own_address(address);
    send_idle_pct = send_idle;
    stall_pct = recv_stall;
    start = parsed_bytes;
    while (parsed_bytes - start < PHASE_BYTES) send_random_frame();
    wait_idle();
  endtask

  task automatic test_backpressure();
    set_own_address(ADDR_GROUP);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b1;
    repeat (3) send_frame(FRAME_BYTES - 6, node_addr, 1'b0, 1'b0);
    wait_idle();
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin : receiver
    int held;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_pop <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        out_pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    rx_result_t got;
    rx_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      got = '{out_status, out_frame_byte, out_byte_index, out_last};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction status %0d byte %02h index %0d",
                                  got.status, got.frame_byte, got.byte_index));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.frame_byte !== want.frame_byte)
          report_mismatch($sformatf("frame byte %02h, want %02h", got.frame_byte,
                                    want.frame_byte));
        if (got.byte_index !== want.byte_index)
          report_mismatch($sformatf("byte index %0d, want %0d", got.byte_index,
                                    want.byte_index));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    foreach (frame_mem[i]) frame_mem[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_noise_and_header();
    test_drop_cases();
    test_random_traffic(0, 0, 8'h00);
    test_random_traffic(45, 0, 8'hFF);
    test_random_traffic(0, 45, 8'($urandom_range(2, 254)));
    test_random_traffic(24, 24, 8'h01);
    test_backpressure();
    $display("run covered %0d parsed bytes, %0d good frames, %0d results checked",
             parsed_bytes, good_frames, results_checked);
    $display("drops: bad header %0d, not addressed %0d, too long %0d, checksum %0d; %0d full cycles",
             drop_count[ST_BAD_HEADER], drop_count[ST_NOT_HERE], drop_count[ST_TOO_LONG],
             drop_count[ST_BAD_SUM], full_stalls);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
